@@ design/rbst_pkg.sv @@
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_W       = COORD_WIDTH + 1;
    localparam int INT_W       = NUM_W;
    localparam int QW          = INT_W + FRAC_BITS;
    localparam int DIV_STEPS   = QW;
    localparam int MAG_W       = COORD_WIDTH;

    localparam logic [1:0] KIND_LINE    = 2'd0;
    localparam logic [1:0] KIND_RAY     = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;

    localparam logic [0:0] REG_QUERY_KIND  = 1'b0;
    localparam logic [0:0] REG_DIR_EPSILON = 1'b1;

    localparam logic signed [COORD_WIDTH-1:0] TMAX =
        {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] T_ONE =
        (FRAC_BITS < COORD_WIDTH - 1) ?
        (COORD_WIDTH)'(64'sd1 <<< FRAC_BITS) : TMAX;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] direction_x;
        logic signed [COORD_WIDTH-1:0] direction_y;
        logic signed [COORD_WIDTH-1:0] direction_z;
        logic signed [COORD_WIDTH-1:0] box_min_x;
        logic signed [COORD_WIDTH-1:0] box_min_y;
        logic signed [COORD_WIDTH-1:0] box_min_z;
        logic signed [COORD_WIDTH-1:0] box_max_x;
        logic signed [COORD_WIDTH-1:0] box_max_y;
        logic signed [COORD_WIDTH-1:0] box_max_z;
    } ray_in_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] t_enter;
        logic signed [COORD_WIDTH-1:0] t_exit;
    } ray_out_t;

endpackage

@@ design/ray_box_slab_test_top.sv @@
// Results are Q16.16; a transaction passes stage 0, the division stages, the ordering
// stage and the output register. Throughput: one transaction per cycle when not stalled;
// six restoring dividers, one quotient bit per stage, run side by side and set the depth.
// A stall freezes the whole pipeline; the output register is freed when taken.
// Reset (rst_n low, asynchronous) empties the pipeline and sets query_kind to ray and
// dir_epsilon to 1.
module ray_box_slab_test_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rbst_pkg::ray_in_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rbst_pkg::ray_out_t                out_data,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);
    import rbst_pkg::*;

    localparam int NS = DIV_STEPS;
    localparam int LW = NS + 3;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QW-1:0]    num;
        logic [QW-1:0]    q;
        logic [MAG_W-1:0] den;
        logic             neg;
    } div_t;

    typedef struct packed {
        logic                          par;
        logic                          par_miss;
    } axis_t;

    logic [1:0]  kind_reg;
    logic [15:0] eps_reg;
    logic [LW-1:0] vld_reg;
    logic          adv;

    // stage 0: differences and magnitudes
    div_t  d0_reg [0:5];
    axis_t ax0_reg [0:2];
    logic signed [COORD_WIDTH-1:0] lo0_reg, hi0_reg;

    div_t  dv_reg [1:NS][0:5];
    axis_t ax_reg [1:NS][0:2];
    logic signed [COORD_WIDTH-1:0] lo_reg [1:NS];
    logic signed [COORD_WIDTH-1:0] hi_reg [1:NS];

    // stage after division: saturated, ordered t per axis
    logic signed [COORD_WIDTH-1:0] tn_reg [0:2];
    logic signed [COORD_WIDTH-1:0] tx_reg [0:2];
    axis_t ax_s_reg [0:2];
    logic signed [COORD_WIDTH-1:0] los_reg, his_reg;

    ray_out_t out_reg;

    assign adv       = !vld_reg[LW-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LW-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_RAY;
            eps_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_KIND:  kind_reg <= cfg_data[1:0];
                REG_DIR_EPSILON: eps_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LW-2:0], in_valid};
    end

    logic signed [COORD_WIDTH-1:0] o_a [0:2], d_a [0:2], mn_a [0:2], mx_a [0:2];
    assign o_a  = '{in_data.origin_x, in_data.origin_y, in_data.origin_z};
    assign d_a  = '{in_data.direction_x, in_data.direction_y, in_data.direction_z};
    assign mn_a = '{in_data.box_min_x, in_data.box_min_y, in_data.box_min_z};
    assign mx_a = '{in_data.box_max_x, in_data.box_max_y, in_data.box_max_z};

    function automatic logic [NUM_W-1:0] mag_n(input logic signed [NUM_W-1:0] v);
        return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    endfunction

    // numerator is the magnitude followed by FRAC_BITS zeros, so q carries the fraction
    function automatic div_t div_step(input div_t s);
        div_t r;
        logic [NUM_W:0] trial;
        r = s;
        trial = {s.rem, s.num[QW-1]};
        r.num = {s.num[QW-2:0], 1'b0};
        if (trial >= {2'b00, s.den})
        begin
            r.rem = NUM_W'(trial - {2'b00, s.den});
            r.q   = {s.q[QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = NUM_W'(trial);
            r.q   = {s.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [NUM_W-1:0] n1, n2;
                logic [MAG_W-1:0] dm;
                n1 = NUM_W'(mn_a[a]) - NUM_W'(o_a[a]);
                n2 = NUM_W'(mx_a[a]) - NUM_W'(o_a[a]);
                dm = d_a[a][COORD_WIDTH-1] ? MAG_W'(-d_a[a]) : MAG_W'(d_a[a]);
                ax0_reg[a].par <= (d_a[a] == '0) || (dm < MAG_W'(eps_reg));
                ax0_reg[a].par_miss <= (o_a[a] < mn_a[a]) || (o_a[a] > mx_a[a]);
                d0_reg[2*a].rem   <= '0;
                d0_reg[2*a].num   <= {mag_n(n1), {FRAC_BITS{1'b0}}};
                d0_reg[2*a].q     <= '0;
                d0_reg[2*a].den   <= (dm == '0) ? MAG_W'(1) : dm;
                d0_reg[2*a].neg   <= n1[NUM_W-1] != d_a[a][COORD_WIDTH-1];
                d0_reg[2*a+1].rem <= '0;
                d0_reg[2*a+1].num <= {mag_n(n2), {FRAC_BITS{1'b0}}};
                d0_reg[2*a+1].q   <= '0;
                d0_reg[2*a+1].den <= (dm == '0) ? MAG_W'(1) : dm;
                d0_reg[2*a+1].neg <= n2[NUM_W-1] != d_a[a][COORD_WIDTH-1];
            end
            case (kind_reg)
                KIND_LINE:
                begin
                    lo0_reg <= -TMAX;
                    hi0_reg <= TMAX;
                end
                KIND_SEGMENT:
                begin
                    lo0_reg <= '0;
                    hi0_reg <= T_ONE;
                end
                default:
                begin
                    lo0_reg <= '0;
                    hi0_reg <= TMAX;
                end
            endcase

            for (int k = 0; k < 6; k++)
                dv_reg[1][k] <= div_step(d0_reg[k]);
            ax_reg[1] <= ax0_reg;
            lo_reg[1] <= lo0_reg;
            hi_reg[1] <= hi0_reg;
            for (int s = 2; s <= NS; s++)
            begin
                for (int k = 0; k < 6; k++)
                    dv_reg[s][k] <= div_step(dv_reg[s-1][k]);
                ax_reg[s] <= ax_reg[s-1];
                lo_reg[s] <= lo_reg[s-1];
                hi_reg[s] <= hi_reg[s-1];
            end

            // saturate, sign and order
            for (int a = 0; a < 3; a++)
            begin
                logic signed [COORD_WIDTH-1:0] t1, t2;
                logic [QW-1:0] q1, q2;
                q1 = dv_reg[NS][2*a].q;
                q2 = dv_reg[NS][2*a+1].q;
                t1 = (q1 > QW'(TMAX)) ? TMAX : COORD_WIDTH'(q1);
                t2 = (q2 > QW'(TMAX)) ? TMAX : COORD_WIDTH'(q2);
                if (dv_reg[NS][2*a].neg)   t1 = -t1;
                if (dv_reg[NS][2*a+1].neg) t2 = -t2;
                tn_reg[a] <= (t1 > t2) ? t2 : t1;
                tx_reg[a] <= (t1 > t2) ? t1 : t2;
            end
            ax_s_reg <= ax_reg[NS];
            los_reg  <= lo_reg[NS];
            his_reg  <= hi_reg[NS];
        end
    end

    // final clip: per axis a max/min; an early miss stops later axes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [COORD_WIDTH-1:0] lo, hi;
            logic h;
            lo = los_reg;
            hi = his_reg;
            h  = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                if (h)
                begin
                    if (ax_s_reg[a].par)
                    begin
                        if (ax_s_reg[a].par_miss)
                            h = 1'b0;
                    end
                    else
                    begin
                        if (tn_reg[a] > lo) lo = tn_reg[a];
                        if (tx_reg[a] < hi) hi = tx_reg[a];
                        if (hi < lo) h = 1'b0;
                    end
                end
            end
            out_reg.hit     <= h;
            out_reg.t_enter <= h ? lo : '0;
            out_reg.t_exit  <= h ? hi : '0;
        end
    end

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.t_enter == '0 && out_data.t_exit == '0)
        else $error("miss result carries nonzero t");
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.t_enter <= out_data.t_exit)
        else $error("hit with exit before enter");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
endmodule

@@ tb/sv/ray_box_slab_test_top_test.sv @@
module ray_box_slab_test_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rbst_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int LATENCY  = QW + 4;
    localparam int WD_LIMIT = 20000;

    typedef logic signed [CW-1:0] coord_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ray_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ray_out_t out_data;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_QUERY_KIND;
    logic [15:0] cfg_data = '0;

    ray_box_slab_test_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [1:0]  kind_q = KIND_RAY;
    logic [15:0] eps_q  = 16'd1;

    ray_in_t  pending_rays[$];
    ray_out_t expected_hits[$];
    int       send_idle = 0;
    int       recv_idle = 0;
    int       mismatches = 0;
    int       stall_cycles = 0;
    bit       timed_out = 1'b0;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // fixed-point quotient, truncated toward zero, saturated to +/-TMAX
    function automatic longint slab_t(longint num, longint den);
        longint unsigned n, d, ip, rem, q;
        n = magnitude(num);
        d = magnitude(den);
        ip = n / d;
        rem = n % d;
        if (ip > (longint'(TMAX) >> FRAC_BITS))
            q = longint'(TMAX);
        else
        begin
            q = ip;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d)
                begin
                    rem = rem - d;
                    q = q | 1;
                end
            end
            if (q > longint'(TMAX))
                q = longint'(TMAX);
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic ray_out_t slab_intersect(ray_in_t r);
        longint lo, hi, o, d, bmin, bmax, t1, t2, tmp;
        bit hit;
        coord_t os[3], ds[3], mins[3], maxs[3];
        ray_out_t res;
        hit = 1'b1;
        os = '{r.origin_x, r.origin_y, r.origin_z};
        ds = '{r.direction_x, r.direction_y, r.direction_z};
        mins = '{r.box_min_x, r.box_min_y, r.box_min_z};
        maxs = '{r.box_max_x, r.box_max_y, r.box_max_z};
        if (kind_q == KIND_LINE)
        begin
            lo = -longint'(TMAX);
            hi = longint'(TMAX);
        end
        else if (kind_q == KIND_SEGMENT)
        begin
            lo = 0;
            hi = longint'(T_ONE);
        end
        else
        begin
            lo = 0;
            hi = longint'(TMAX);
        end
        for (int a = 0; a < 3 && hit; a++)
        begin
            o = os[a];
            d = ds[a];
            bmin = mins[a];
            bmax = maxs[a];
            if (d == 0 || magnitude(d) < eps_q)
            begin
                if (o < bmin || o > bmax)
                    hit = 1'b0;
            end
            else
            begin
                t1 = slab_t(bmin - o, d);
                t2 = slab_t(bmax - o, d);
                if (t1 > t2)
                begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > lo) lo = t1;
                if (t2 < hi) hi = t2;
                if (hi < lo) hit = 1'b0;
            end
        end
        if (!hit)
        begin
            lo = 0;
            hi = 0;
        end
        res.hit = hit;
        res.t_enter = coord_t'(lo);
        res.t_exit = coord_t'(hi);
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_rays.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        ray_out_t exp_res;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_hits.push_back(slab_intersect(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", out_data);
                end
                else
                begin
                    exp_res = expected_hits.pop_front();
                    if (out_data !== exp_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                                exp_res.hit, exp_res.t_enter, exp_res.t_exit,
                                out_data.hit, out_data.t_enter, out_data.t_exit);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else if (pending_rays.size() > 0 || expected_hits.size() > 0)
                stall_cycles++;
            if (stall_cycles >= WD_LIMIT)
                timed_out = 1'b1;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_QUERY_KIND)
            kind_q = val[1:0];
        else
            eps_q = val;
    endtask

    task automatic drain();
        while ((pending_rays.size() > 0 || expected_hits.size() > 0 || in_valid)
               && !timed_out)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom());
            1: return coord_t'($urandom_range(20 << 16)) - coord_t'(10 << 16);
            2: return coord_t'($urandom_range(64)) - coord_t'(32);
            default:
                case ($urandom_range(3))
                    0: return coord_t'(TMAX);
                    1: return {1'b1, {(CW-1){1'b0}}};
                    2: return '0;
                    default: return -coord_t'(TMAX);
                endcase
        endcase
    endfunction

    // mostly small-range rays and boxes, boxes mostly ordered; some raw noise and corner values
    function automatic ray_in_t rand_ray();
        ray_in_t r;
        int m;
        coord_t a, b;
        coord_t o[3], d[3], lo[3], hi[3];
        m = $urandom_range(9);
        for (int k = 0; k < 3; k++)
        begin
            if (m == 0)
            begin
                o[k] = rand_coord(0); d[k] = rand_coord(0);
                lo[k] = rand_coord(0); hi[k] = rand_coord(0);
            end
            else if (m == 1)
            begin
                o[k] = rand_coord($urandom_range(3)); d[k] = rand_coord($urandom_range(3));
                lo[k] = rand_coord($urandom_range(3)); hi[k] = rand_coord($urandom_range(3));
            end
            else
            begin
                o[k] = rand_coord(1);
                d[k] = ($urandom_range(5) == 0) ? rand_coord(2) : rand_coord(1);
                a = rand_coord(1);
                b = rand_coord(1);
                if ($urandom_range(7) == 0)
                begin
                    lo[k] = a; hi[k] = b;
                end
                else
                begin
                    lo[k] = (a < b) ? a : b; hi[k] = (a < b) ? b : a;
                end
            end
        end
        r.origin_x = o[0]; r.origin_y = o[1]; r.origin_z = o[2];
        r.direction_x = d[0]; r.direction_y = d[1]; r.direction_z = d[2];
        r.box_min_x = lo[0]; r.box_min_y = lo[1]; r.box_min_z = lo[2];
        r.box_max_x = hi[0]; r.box_max_y = hi[1]; r.box_max_z = hi[2];
        return r;
    endfunction

    function automatic ray_in_t make_ray(coord_t o, coord_t d, coord_t bmin, coord_t bmax);
        ray_in_t r;
        r.origin_x = o; r.origin_y = o; r.origin_z = o;
        r.direction_x = d; r.direction_y = d; r.direction_z = d;
        r.box_min_x = bmin; r.box_min_y = bmin; r.box_min_z = bmin;
        r.box_max_x = bmax; r.box_max_y = bmax; r.box_max_z = bmax;
        return r;
    endfunction

    task automatic load_directed();
        coord_t one, neg;
        ray_in_t r;
        one = T_ONE;
        neg = {1'b1, {(CW-1){1'b0}}};
        pending_rays.push_back(make_ray(0, one, one, 2 * one));
        pending_rays.push_back(make_ray(0, -one, one, 2 * one));
        pending_rays.push_back(make_ray(0, 0, -one, one));        // zero dir inside
        pending_rays.push_back(make_ray(3 * one, 0, -one, one));  // zero dir outside
        pending_rays.push_back(make_ray(0, 0, one, -one));        // parallel inverted box
        pending_rays.push_back(make_ray(0, one, 2 * one, -one));  // inverted, sloped
        pending_rays.push_back(make_ray(0, 1, -one, one));        // tiny dir, saturates
        pending_rays.push_back(make_ray(neg, coord_t'(TMAX), neg, coord_t'(TMAX)));
        pending_rays.push_back(make_ray(coord_t'(TMAX), neg, neg, coord_t'(TMAX)));
        pending_rays.push_back(make_ray(coord_t'(TMAX), 1, neg, neg));
        pending_rays.push_back(make_ray(-one, one, 0, 0));         // touching, equal t
        pending_rays.push_back(make_ray(0, one, one, one));        // t exactly one
        pending_rays.push_back(make_ray('1, '1, '1, '1));
        r = make_ray(0, one, -one, one);
        r.direction_y = 3;                                       // near parallel
        r.direction_z = -3;
        pending_rays.push_back(r);
        r.box_min_x = 3 * one;
        pending_rays.push_back(r);
        r = make_ray(0, one, -one, one);
        r.box_min_y = 5 * one;                                  // disjoint slabs
        r.box_max_y = 6 * one;
        pending_rays.push_back(r);
    endtask

    initial
    begin
        logic [1:0]  kinds[6];
        logic [15:0] epss[6];
        kinds = '{KIND_RAY, KIND_LINE, KIND_SEGMENT, 2'd3, KIND_LINE, KIND_SEGMENT};
        epss = '{16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd16, 16'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 6 && !timed_out; phase++)
        begin
            write_reg(REG_QUERY_KIND, {14'd0, kinds[phase]});
            write_reg(REG_DIR_EPSILON, epss[phase]);
            if (phase < 2)
            begin
                send_idle = 32; recv_idle = 67;
            end
            else if (phase < 4)
            begin
                send_idle = 67; recv_idle = 32;
            end
            else
            begin
                send_idle = 0; recv_idle = 0;
            end
            load_directed();
            repeat (240) pending_rays.push_back(rand_ray());
            drain();
        end
        if (timed_out)
            $display("ray_box_slab_test_top_test failed");
        else if (mismatches == 0)
            $display("ray_box_slab_test_top_test passed");
        else
            $display("ray_box_slab_test_top_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rbst_pkg.sv
design/ray_box_slab_test_top.sv
tb/sv/ray_box_slab_test_top_test.sv
